// ===== rtl/srtpc_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// srtpc_pkg
// Shared widths, register indexes, reset values and status codes of the
// step rate timer period calculator.
// ============================================================================
package srtpc_pkg;

    // Field widths
    localparam int SPEED_W   = 16;
    localparam int PRESC_W   = 16;
    localparam int RELOAD_W  = 16;
    localparam int COMPARE_W = 15;
    localparam int STATUS_W  = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;

    localparam int CLK_HZ_W = 28;
    localparam int PPR_W    = 16;
    localparam int LEAD_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_CLOCK_HZ = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_REV = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREW_LEAD_MM  = 3'd4;

    localparam logic [CLK_HZ_W-1:0] RST_TIMER_CLOCK_HZ = 28'd72000000;
    localparam logic [SPEED_W-1:0]  RST_MAX_SPEED      = 16'd600;
    localparam logic [SPEED_W-1:0]  RST_MIN_SPEED      = 16'd0;
    localparam logic [PPR_W-1:0]    RST_PULSES_PER_REV = 16'd5000;
    localparam logic [LEAD_W-1:0]   RST_SCREW_LEAD_MM  = 8'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CLAMP_HIGH = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CLAMP_LOW  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO_SPEED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PRESC_SAT  = 3'd4;

    localparam logic [PRESC_W-1:0]  PRESC_MAX  = 16'hFFFF;
    localparam logic [RELOAD_W-1:0] RELOAD_MAX = 16'hFFFF;

endpackage

// ===== rtl/srtpc_in_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// srtpc_in_if
// Request channel: one requested speed per handshake.
// ============================================================================
interface srtpc_in_if;
    logic                          valid;
    logic                          ready;
    logic [srtpc_pkg::SPEED_W-1:0] speed;

    modport source (output valid, output speed, input ready);
    modport sink   (input valid, input speed, output ready);
endinterface

// ===== rtl/srtpc_out_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// srtpc_out_if
// Result channel: prescaler, reload, compare and status per handshake.
// ============================================================================
interface srtpc_out_if;
    logic                            valid;
    logic                            ready;
    logic [srtpc_pkg::PRESC_W-1:0]   prescaler;
    logic [srtpc_pkg::RELOAD_W-1:0]  reload;
    logic [srtpc_pkg::COMPARE_W-1:0] compare;
    logic [srtpc_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output prescaler, output reload, output compare,
                    output status, input ready);
    modport sink   (input valid, input prescaler, input reload, input compare,
                    input status, output ready);
endinterface

// ===== rtl/step_rate_timer_period_calc.sv =====
`timescale 1ns / 1ps
// ============================================================================
// step_rate_timer_period_calc
// Turns a requested linear speed into timer prescaler, reload and 50% compare
// values using a bit-serial shift-add multiplier and a restoring divider.
// ============================================================================
//
//  channel   dir  handshake            payload
//  --------  ---  -------------------  ---------------------------------------
//  i_req     in   valid / ready        speed
//  o_rsp     out  valid / ready        prescaler, reload, compare, status
//  i_cfg_*   in   i_cfg_we, no wait    i_cfg_idx, i_cfg_data
//
//  A normal request runs three shift-add multiplies, two restoring
//  divisions, a step that sets up the second division and one that parks
//  the result. A zero rate skips the arithmetic; a saturated prescaler
//  skips the third multiply and the second division.
//  One request is in flight at a time; the next is taken once the result is
//  parked in the output register, even while the sink stalls it.
//  Reset (synchronous, active low) restores the register defaults and drops
//  any request in flight.
//
module step_rate_timer_period_calc (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    srtpc_in_if.sink                            i_req,
    srtpc_out_if.source                         o_rsp,
    input  logic                                i_cfg_we,
    input  logic [srtpc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [srtpc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import srtpc_pkg::*;

    // Shift-add multiplier: 32-bit multiplicand by 17-bit multiplier
    localparam int MA_W  = 32;
    localparam int MB_W  = 17;
    localparam int ACC_W = MA_W + MB_W;
    localparam int N_W   = 42;          // timer clock * 60 * lead
    localparam int K_W   = 14;          // 60 * lead
    // Restoring divider
    localparam int NUM_W = 50;
    localparam int QUO_W = 17;
    localparam int D_W   = 49;          // m0 * 131073

    localparam logic [5:0] MUL_LAST = 6'(MB_W - 1);
    localparam logic [5:0] DIV_LAST = 6'(NUM_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_M0,
        S_MUL_N,
        S_DIV_P,
        S_MUL_M,
        S_PREP_Q,
        S_DIV_Q,
        S_DONE
    } t_state;

    // Configuration registers
    logic [CLK_HZ_W-1:0] r_clk_hz;
    logic [SPEED_W-1:0]  r_max_speed;
    logic [SPEED_W-1:0]  r_min_speed;
    logic [PPR_W-1:0]    r_ppr;
    logic [LEAD_W-1:0]   r_lead;

    t_state               r_state;
    logic [5:0]           r_cnt;
    logic [STATUS_W-1:0]  r_stat;
    logic [MA_W-1:0]      r_m0;
    logic [N_W-1:0]       r_n;
    logic [PRESC_W-1:0]   r_p;
    logic [RELOAD_W-1:0]  r_rel;

    // Multiplier datapath
    logic [ACC_W-1:0]     r_ma;
    logic [MB_W-1:0]      r_mb;
    logic [ACC_W-1:0]     r_acc;

    // Divider datapath
    logic [NUM_W-1:0]     r_num;
    logic [NUM_W-1:0]     r_den;
    logic [NUM_W-1:0]     r_rem;
    logic [QUO_W-1:0]     r_quo;
    logic                 r_qhi;

    // Output register
    logic                 r_ov;
    logic [PRESC_W-1:0]   r_o_presc;
    logic [RELOAD_W-1:0]  r_o_rel;
    logic [STATUS_W-1:0]  r_o_stat;

    // Combinational
    logic [SPEED_W-1:0]   n_spd_hi;
    logic [SPEED_W-1:0]   n_spd;
    logic [STATUS_W-1:0]  n_stat;
    logic [K_W-1:0]       n_k;
    logic [ACC_W-1:0]     n_acc;
    logic [NUM_W:0]       n_rem_sh;
    logic [NUM_W+1:0]     n_diff;
    logic                 n_ge;
    logic [NUM_W-1:0]     n_rem;
    logic [QUO_W-1:0]     n_quo;
    logic                 n_qhi;
    logic [D_W-1:0]       n_d;
    logic [QUO_W-1:0]     n_q_m1;

    // ---- configuration writes ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz    <= RST_TIMER_CLOCK_HZ;
            r_max_speed <= RST_MAX_SPEED;
            r_min_speed <= RST_MIN_SPEED;
            r_ppr       <= RST_PULSES_PER_REV;
            r_lead      <= RST_SCREW_LEAD_MM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIMER_CLOCK_HZ: r_clk_hz    <= i_cfg_data[CLK_HZ_W-1:0];
                CFG_MAX_SPEED:      r_max_speed <= i_cfg_data[SPEED_W-1:0];
                CFG_MIN_SPEED:      r_min_speed <= i_cfg_data[SPEED_W-1:0];
                CFG_PULSES_PER_REV: r_ppr       <= i_cfg_data[PPR_W-1:0];
                CFG_SCREW_LEAD_MM:  r_lead      <= i_cfg_data[LEAD_W-1:0];
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    always_comb begin
        // Clamp high first, then low; the low clamp wins a crossed range
        n_spd_hi = (i_req.speed > r_max_speed) ? r_max_speed : i_req.speed;
        n_stat   = (i_req.speed > r_max_speed) ? ST_CLAMP_HIGH : ST_OK;
        n_spd    = n_spd_hi;
        if (n_spd_hi < r_min_speed) begin
            n_spd  = r_min_speed;
            n_stat = ST_CLAMP_LOW;
        end

        // 60 * lead = 64*lead - 4*lead
        n_k = {r_lead, 6'b0} - {4'b0, r_lead, 2'b0};

        // One shift-add step
        n_acc = r_acc + (r_mb[0] ? r_ma : '0);

        // One restoring division step: bring down the next numerator bit
        n_rem_sh = {r_rem, r_num[NUM_W-1]};
        n_diff   = {1'b0, n_rem_sh} - {2'b0, r_den};
        n_ge     = ~n_diff[NUM_W+1];
        n_rem    = n_ge ? n_diff[NUM_W-1:0] : n_rem_sh[NUM_W-1:0];
        n_quo    = {r_quo[QUO_W-2:0], n_ge};
        // Sticky flag: any quotient bit that leaves the 17-bit window
        n_qhi    = r_qhi | r_quo[QUO_W-1];

        // Prescaler search divisor: m0 * 131073 = (m0 << 17) + m0
        n_d    = {r_m0, 17'b0} + {17'b0, r_m0};
        n_q_m1 = r_quo - 17'd1;
    end

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            // Drop the parked result once taken, unless a new one replaces it
            if (r_ov && o_rsp.ready && r_state != S_DONE) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        if (n_spd == '0 || r_ppr == '0) begin
                            // Zero rate: skip the arithmetic
                            r_stat  <= ST_ZERO_SPEED;
                            r_p     <= '0;
                            r_rel   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_stat  <= n_stat;
                            r_ma    <= {{(ACC_W-PPR_W){1'b0}}, r_ppr};
                            r_mb    <= {{(MB_W-SPEED_W){1'b0}}, n_spd};
                            r_acc   <= '0;
                            r_cnt   <= '0;
                            r_state <= S_MUL_M0;
                        end
                    end
                end

                S_MUL_M0: begin
                    r_acc <= n_acc;
                    r_ma  <= r_ma << 1;
                    r_mb  <= r_mb >> 1;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == MUL_LAST) begin
                        // m0 = speed * pulses_per_rev; start N = clk * 60 * lead
                        r_m0    <= n_acc[MA_W-1:0];
                        r_ma    <= {{(ACC_W-CLK_HZ_W){1'b0}}, r_clk_hz};
                        r_mb    <= {{(MB_W-K_W){1'b0}}, n_k};
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_MUL_N;
                    end
                end

                S_MUL_N: begin
                    r_acc <= n_acc;
                    r_ma  <= r_ma << 1;
                    r_mb  <= r_mb >> 1;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == MUL_LAST) begin
                        // p = 2N / (131073 * m0)
                        r_n     <= n_acc[N_W-1:0];
                        r_num   <= {{(NUM_W-N_W-1){1'b0}}, n_acc[N_W-1:0], 1'b0};
                        r_den   <= {{(NUM_W-D_W){1'b0}}, n_d};
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_qhi   <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= S_DIV_P;
                    end
                end

                S_DIV_P: begin
                    r_rem <= n_rem;
                    r_num <= r_num << 1;
                    r_quo <= n_quo;
                    r_qhi <= n_qhi;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == DIV_LAST) begin
                        if (n_qhi || n_quo[QUO_W-1]) begin
                            // No prescaler fits: saturate both counters
                            r_p     <= PRESC_MAX;
                            r_rel   <= RELOAD_MAX;
                            r_stat  <= ST_PRESC_SAT;
                            r_state <= S_DONE;
                        end else begin
                            // m = m0 * (p + 1)
                            r_p     <= n_quo[PRESC_W-1:0];
                            r_ma    <= {{(ACC_W-MA_W){1'b0}}, r_m0};
                            r_mb    <= {1'b0, n_quo[PRESC_W-1:0]} + 17'd1;
                            r_acc   <= '0;
                            r_cnt   <= '0;
                            r_state <= S_MUL_M;
                        end
                    end
                end

                S_MUL_M: begin
                    r_acc <= n_acc;
                    r_ma  <= r_ma << 1;
                    r_mb  <= r_mb >> 1;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == MUL_LAST) begin
                        r_state <= S_PREP_Q;
                    end
                end

                S_PREP_Q: begin
                    // q = (2N + m) / (2m), rounds the period to nearest
                    r_num   <= {{(NUM_W-N_W-1){1'b0}}, r_n, 1'b0}
                               + {{(NUM_W-ACC_W){1'b0}}, r_acc};
                    r_den   <= {r_acc, 1'b0};
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_qhi   <= 1'b0;
                    r_cnt   <= '0;
                    r_state <= S_DIV_Q;
                end

                S_DIV_Q: begin
                    r_rem <= n_rem;
                    r_num <= r_num << 1;
                    r_quo <= n_quo;
                    r_qhi <= n_qhi;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    if (!r_ov || o_rsp.ready) begin
                        r_ov      <= 1'b1;
                        r_o_presc <= r_p;
                        r_o_stat  <= r_stat;
                        // Only the full path leaves a quotient to convert
                        if (r_stat == ST_ZERO_SPEED || r_stat == ST_PRESC_SAT) begin
                            r_o_rel <= r_rel;
                        end else if (r_quo == '0) begin
                            r_o_rel <= '0;
                        end else begin
                            r_o_rel <= n_q_m1[RELOAD_W-1:0];
                        end
                        r_state <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_ov;
    assign o_rsp.prescaler = r_o_presc;
    assign o_rsp.reload    = r_o_rel;
    assign o_rsp.compare   = r_o_rel[RELOAD_W-1:1];
    assign o_rsp.status    = r_o_stat;

`ifndef SYNTHESIS
    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(r_state == S_DONE))
        else $error("result appeared without a finished computation");

    a_req_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state != S_IDLE))
        else $error("accepted request did not start the sequencer");

    a_sat_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_PRESC_SAT) |->
        (o_rsp.prescaler == PRESC_MAX && o_rsp.reload == RELOAD_MAX))
        else $error("saturated status without saturated counters");

    a_zero_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_ZERO_SPEED) |->
        (o_rsp.prescaler == '0 && o_rsp.reload == '0))
        else $error("zero speed status with nonzero counters");
`endif

endmodule
